### rtl/assert_macros.svh
// assertion macros used by the checker file ckd_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must never hold outside reset
`define CKD_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define CKD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent after a delay given by the argument n
`define CKD_ASSERT_DELAY(label, clk, rst_n, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("assertion failed");

`endif

### rtl/ckd_pkg.sv
// constants, types and helper functions of the kinematic car derivative core
// no dependencies
package ckd_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int DATA_WIDTH    = 16;

    localparam int ATAN_DEPTH = 24;
    localparam int SHIFT_W    = $clog2(ATAN_DEPTH);
    localparam int VEC_W      = 32;
    localparam int SPEED_W    = 16;
    localparam int HEADING_W  = 16;
    localparam int STEER_W    = 15;
    localparam int WB_W       = 16;
    localparam int PROD_W     = SPEED_W + VEC_W;
    localparam int DEN_P_W    = VEC_W + WB_W + 1;
    localparam int NUM_W      = PROD_W + 8;
    localparam int DEN_W      = VEC_W + WB_W;
    localparam int QB         = DATA_WIDTH + 1;
    localparam int NIDX_W     = $clog2(NUM_W);
    localparam int LATENCY    = CORDIC_STAGES + QB + 5;

    localparam logic [WB_W-1:0] WB_RESET = 16'd256;
    localparam logic signed [VEC_W+1:0] PI_Q29 = 34'sd1686629713;
    localparam logic signed [VEC_W-1:0] INV_GAIN_Q30 = 32'sh26DD3B6A;
    localparam logic signed [PROD_W:0] ROUND_HALF = (PROD_W+1)'(64'sd1 <<< 29);
    localparam logic signed [PROD_W:0] WIDE_HI =
        (PROD_W+1)'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
    localparam logic signed [PROD_W:0] WIDE_LO = -WIDE_HI - (PROD_W+1)'(1);
    localparam logic signed [DATA_WIDTH-1:0] SAT_HI = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] SAT_LO = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [QB-1:0] Q_POS_MAX = QB'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
    localparam logic [QB-1:0] Q_NEG_MAX = QB'(64'd1 << (DATA_WIDTH - 1));

    // arctangent of 2^-i in Q29 radians
    localparam logic signed [VEC_W-1:0] ATAN_Q29 [ATAN_DEPTH] = '{
        32'sd421657428, 32'sd248918915, 32'sd131521918, 32'sd66762579,
        32'sd33510843,  32'sd16771758,  32'sd8387925,   32'sd4194219,
        32'sd2097141,   32'sd1048575,   32'sd524288,    32'sd262144,
        32'sd131072,    32'sd65536,     32'sd32768,     32'sd16384,
        32'sd8192,      32'sd4096,      32'sd2048,      32'sd1024,
        32'sd512,       32'sd256,       32'sd128,       32'sd64
    };

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] z;
    } cordic_vec_t;

    typedef struct packed {
        cordic_vec_t vec;
        logic        neg;
    } angle_prep_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic                      neg_h;
        logic                      neg_s;
    } cord_side_t;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QB-1:0]    q;
        logic [NUM_W-1:0] n;
        logic [DEN_W-1:0] ad;
    } div_state_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] rx;
        logic signed [DATA_WIDTH-1:0] ry;
        logic                         sat_xy;
        logic                         negative;
        logic                         zero_num;
        logic                         ovf;
    } div_side_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] val;
        logic                         clip;
    } sat_t;

    // fold an angle beyond half pi back by pi and set up the cordic start vector
    function automatic angle_prep_t prep_angle(input logic signed [VEC_W-1:0] z);
        logic signed [VEC_W+1:0] zw;
        logic signed [VEC_W+1:0] z2;
        angle_prep_t r;
        zw = (VEC_W+2)'(z);
        z2 = zw <<< 1;
        r.vec.x = INV_GAIN_Q30;
        r.vec.y = '0;
        r.vec.z = z;
        r.neg   = 1'b0;
        if (z2 > PI_Q29) begin
            r.vec.z = VEC_W'(zw - PI_Q29);
            r.neg   = 1'b1;
        end else if (z2 < -PI_Q29) begin
            r.vec.z = VEC_W'(zw + PI_Q29);
            r.neg   = 1'b1;
        end
        return r;
    endfunction

    // round a Q30 product to nearest, ties away from zero, and clip
    function automatic sat_t round_sat(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W:0] w;
        logic signed [PROD_W:0] r;
        sat_t res;
        w = (PROD_W+1)'(v);
        if (!w[PROD_W]) begin
            r = (w + ROUND_HALF) >>> 30;
        end else begin
            r = -((-w + ROUND_HALF) >>> 30);
        end
        res.clip = 1'b0;
        res.val  = DATA_WIDTH'(r);
        if (r > WIDE_HI) begin
            res.val  = SAT_HI;
            res.clip = 1'b1;
        end else if (r < WIDE_LO) begin
            res.val  = SAT_LO;
            res.clip = 1'b1;
        end
        return res;
    endfunction

endpackage

### rtl/ckd_cordic_cell.sv
// one rotation step of the sine/cosine chain
// depends on ckd_pkg
module ckd_cordic_cell (
    input  logic                              clk,
    input  ckd_pkg::cordic_vec_t              vin,
    input  logic [ckd_pkg::SHIFT_W-1:0]       shift,
    input  logic signed [ckd_pkg::VEC_W-1:0]  atan,
    output ckd_pkg::cordic_vec_t              vout
);
    import ckd_pkg::*;

    cordic_vec_t             vec_reg;
    cordic_vec_t             vec_next;
    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;

    // rotate toward zero residual angle
    always_comb
    begin
        dx = vin.y >>> shift;
        dy = vin.x >>> shift;
        if (!vin.z[VEC_W-1])
        begin
            vec_next.x = vin.x - dx;
            vec_next.y = vin.y + dy;
            vec_next.z = vin.z - atan;
        end
        else
        begin
            vec_next.x = vin.x + dx;
            vec_next.y = vin.y - dy;
            vec_next.z = vin.z + atan;
        end
    end

    always_ff @(posedge clk)
    begin
        vec_reg <= vec_next;
    end

    assign vout = vec_reg;

endmodule

### rtl/ckd_div_cell.sv
// one quotient bit of the restoring divider chain
// depends on ckd_pkg
module ckd_div_cell (
    input  logic                         clk,
    input  ckd_pkg::div_state_t          din,
    input  logic [ckd_pkg::NIDX_W-1:0]   bidx,
    output ckd_pkg::div_state_t          dout
);
    import ckd_pkg::*;

    div_state_t       st_reg;
    div_state_t       st_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   dvs;
    logic             ge;

    // shift in the next dividend bit and subtract when it fits
    always_comb
    begin
        trial        = {din.rem, din.n[bidx]};
        dvs          = {1'b0, din.ad};
        ge           = (trial >= dvs);
        st_next      = din;
        st_next.rem  = ge ? DEN_W'(trial - dvs) : DEN_W'(trial);
        st_next.q    = {din.q[QB-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
    end

    assign dout = st_reg;

endmodule

### rtl/car_kinematic_derivative_core.sv
// kinematic car derivative core: cordic cell chains, multipliers, divider cell chain
// start to done: input register, cordic cells, product, magnitude and divider input registers, divider cells, output
// throughput: one item per cycle; busy stays low and the chains advance every cycle
// the depth is set by the two cordic chains and the one-bit-per-cell divider chain
// reset clears the valid line and sets wheelbase to 1.0 m; the receiver cannot stall
module car_kinematic_derivative_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [ckd_pkg::HEADING_W-1:0]  heading,
    input  logic signed [ckd_pkg::STEER_W-1:0]    steering,
    input  logic signed [ckd_pkg::SPEED_W-1:0]    speed,
    input  logic                                  cfg_we,
    input  logic [ckd_pkg::WB_W-1:0]              cfg_wdata,
    output logic                                  done,
    output logic signed [ckd_pkg::DATA_WIDTH-1:0] rate_x,
    output logic signed [ckd_pkg::DATA_WIDTH-1:0] rate_y,
    output logic signed [ckd_pkg::DATA_WIDTH-1:0] rate_heading,
    output logic                                  saturated
);
    import ckd_pkg::*;

    logic [LATENCY-1:0]  vld_reg;
    logic [WB_W-1:0]     wheelbase_reg;

    angle_prep_t         prep_h;
    angle_prep_t         prep_s;
    cordic_vec_t         vh [CORDIC_STAGES+1];
    cordic_vec_t         vs [CORDIC_STAGES+1];
    cord_side_t          cside_reg [CORDIC_STAGES+1];

    logic signed [VEC_W-1:0]   ch;
    logic signed [VEC_W-1:0]   sh;
    logic signed [VEC_W-1:0]   cs;
    logic signed [VEC_W-1:0]   ss;
    logic signed [PROD_W-1:0]  px_reg;
    logic signed [PROD_W-1:0]  py_reg;
    logic signed [PROD_W-1:0]  ps_reg;
    logic signed [DEN_P_W-1:0] pd_reg;

    sat_t                sx;
    sat_t                sy;
    logic signed [NUM_W-1:0] num;
    logic [NUM_W-1:0]    an;
    logic [DEN_W-1:0]    ad;
    logic [NUM_W-1:0]    n_reg;
    logic [DEN_W-1:0]    ad_reg;
    div_side_t           aside_reg;

    logic [NUM_W-1:0]    hi_part;
    div_side_t           aside_chk;
    div_state_t          dv [QB+1];
    div_side_t           dside_reg [QB+1];

    logic [QB-1:0]       qf;
    logic [QB-1:0]       qneg;
    div_side_t           fside;
    logic signed [DATA_WIDTH-1:0] rh_next;
    logic                rh_clip;

    assign busy = 1'b0;

    // valid line and wheelbase register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            wheelbase_reg <= WB_RESET;
        end
        else
        begin
            vld_reg <= {vld_reg[LATENCY-2:0], start && !busy};
            if (cfg_we)
            begin
                wheelbase_reg <= cfg_wdata;
            end
        end
    end

    assign done = vld_reg[LATENCY-1];

    // angle fold and start vectors
    always_comb
    begin
        prep_h = prep_angle(VEC_W'({heading, 16'b0}));
        prep_s = prep_angle(VEC_W'(signed'({steering, 16'b0})));
    end

    always_ff @(posedge clk)
    begin
        vh[0]              <= prep_h.vec;
        vs[0]              <= prep_s.vec;
        cside_reg[0].speed <= speed;
        cside_reg[0].neg_h <= prep_h.neg;
        cside_reg[0].neg_s <= prep_s.neg;
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            cside_reg[i+1] <= cside_reg[i];
        end
    end

    // cordic cell chains for heading and steering
    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cordic
        ckd_cordic_cell u_h (
            .clk   (clk),
            .vin   (vh[g]),
            .shift (SHIFT_W'(g)),
            .atan  (ATAN_Q29[g]),
            .vout  (vh[g+1])
        );
        ckd_cordic_cell u_s (
            .clk   (clk),
            .vin   (vs[g]),
            .shift (SHIFT_W'(g)),
            .atan  (ATAN_Q29[g]),
            .vout  (vs[g+1])
        );
    end

    // undo the fold and multiply
    always_comb
    begin
        ch = cside_reg[CORDIC_STAGES].neg_h ? -vh[CORDIC_STAGES].x : vh[CORDIC_STAGES].x;
        sh = cside_reg[CORDIC_STAGES].neg_h ? -vh[CORDIC_STAGES].y : vh[CORDIC_STAGES].y;
        cs = cside_reg[CORDIC_STAGES].neg_s ? -vs[CORDIC_STAGES].x : vs[CORDIC_STAGES].x;
        ss = cside_reg[CORDIC_STAGES].neg_s ? -vs[CORDIC_STAGES].y : vs[CORDIC_STAGES].y;
    end

    always_ff @(posedge clk)
    begin
        px_reg <= PROD_W'(cside_reg[CORDIC_STAGES].speed) * PROD_W'(ch);
        py_reg <= PROD_W'(cside_reg[CORDIC_STAGES].speed) * PROD_W'(sh);
        ps_reg <= PROD_W'(cside_reg[CORDIC_STAGES].speed) * PROD_W'(ss);
        pd_reg <= DEN_P_W'(cs) * DEN_P_W'(signed'({1'b0, wheelbase_reg}));
    end

    // round the velocities, take magnitudes for the divider
    always_comb
    begin
        sx  = round_sat(px_reg);
        sy  = round_sat(py_reg);
        num = NUM_W'(ps_reg) <<< 8;
        an  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        ad  = pd_reg[DEN_P_W-1] ? DEN_W'(-pd_reg) : DEN_W'(pd_reg);
    end

    always_ff @(posedge clk)
    begin
        n_reg              <= an + NUM_W'(ad >> 1);
        ad_reg             <= ad;
        aside_reg.rx       <= sx.val;
        aside_reg.ry       <= sy.val;
        aside_reg.sat_xy   <= sx.clip | sy.clip;
        aside_reg.negative <= num[NUM_W-1] != pd_reg[DEN_P_W-1];
        aside_reg.zero_num <= (ps_reg == '0);
        aside_reg.ovf      <= 1'b0;
    end

    // quotient range check and initial remainder
    assign hi_part = n_reg >> QB;

    always_comb
    begin
        aside_chk     = aside_reg;
        aside_chk.ovf = (hi_part >= NUM_W'(ad_reg));
    end

    always_ff @(posedge clk)
    begin
        dv[0].rem     <= DEN_W'(hi_part);
        dv[0].q       <= '0;
        dv[0].n       <= n_reg;
        dv[0].ad      <= ad_reg;
        dside_reg[0]  <= aside_chk;
        for (int i = 0; i < QB; i++)
        begin
            dside_reg[i+1] <= dside_reg[i];
        end
    end

    // divider cell chain, most significant quotient bit first
    for (genvar g = 0; g < QB; g++)
    begin : g_div
        ckd_div_cell u_d (
            .clk  (clk),
            .din  (dv[g]),
            .bidx (NIDX_W'(QB - 1 - g)),
            .dout (dv[g+1])
        );
    end

    // sign, clip and output register
    always_comb
    begin
        qf      = dv[QB].q;
        qneg    = -qf;
        fside   = dside_reg[QB];
        rh_clip = 1'b0;
        rh_next = '0;
        priority if (fside.zero_num)
        begin
            rh_next = '0;
        end
        else if (fside.ovf)
        begin
            rh_next = fside.negative ? SAT_LO : SAT_HI;
            rh_clip = 1'b1;
        end
        else if (fside.negative)
        begin
            if (qf > Q_NEG_MAX)
            begin
                rh_next = SAT_LO;
                rh_clip = 1'b1;
            end
            else
            begin
                rh_next = DATA_WIDTH'(qneg);
            end
        end
        else
        begin
            if (qf > Q_POS_MAX)
            begin
                rh_next = SAT_HI;
                rh_clip = 1'b1;
            end
            else
            begin
                rh_next = DATA_WIDTH'(qf);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rate_x       <= fside.rx;
        rate_y       <= fside.ry;
        rate_heading <= rh_next;
        saturated    <= fside.sat_xy | rh_clip;
    end

endmodule

### rtl/ckd_checker.sv
// port-level checks of the kinematic car derivative core, bound to the top level
// depends on ckd_pkg and assert_macros.svh
`include "assert_macros.svh"

module ckd_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  start,
    input logic                                  busy,
    input logic                                  done,
    input logic signed [ckd_pkg::DATA_WIDTH-1:0] rate_x,
    input logic signed [ckd_pkg::DATA_WIDTH-1:0] rate_y,
    input logic signed [ckd_pkg::DATA_WIDTH-1:0] rate_heading,
    input logic                                  saturated
);
    import ckd_pkg::*;

    logic at_limit;

    // some rate sits at a range limit
    assign at_limit = rate_x == SAT_HI || rate_x == SAT_LO || rate_y == SAT_HI ||
                      rate_y == SAT_LO || rate_heading == SAT_HI || rate_heading == SAT_LO;

    // the core never holds off a transfer
    `CKD_ASSERT_NEVER(a_busy_low, clk, rst_n, busy)

    // every accepted transfer yields a result on done
    `CKD_ASSERT_DELAY(a_latency, clk, rst_n, start && !busy, LATENCY, done)

    // no result without a transfer that caused it
    `CKD_ASSERT_IMPLY(a_no_spurious, clk, rst_n, done, $past(start && !busy, LATENCY))

    // the flag is only set with some rate at a range limit
    `CKD_ASSERT_IMPLY(a_sat_flag, clk, rst_n, done && saturated, at_limit)

endmodule

bind car_kinematic_derivative_core ckd_checker u_ckd_checker (.*);

### tb/sv/tb_car_kinematic_derivative_core.sv
// self-checking testbench of the kinematic car derivative core
// needs ckd_pkg and car_kinematic_derivative_core; predicts each result in a scoreboard class
module tb_car_kinematic_derivative_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ckd_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = LATENCY + 8;

    // expected outputs of one transfer
    typedef struct {
        logic signed [DATA_WIDTH-1:0] rx;
        logic signed [DATA_WIDTH-1:0] ry;
        logic signed [DATA_WIDTH-1:0] rh;
        logic                         sat;
    } rates_t;

    // predicts the derivatives and checks the results in order
    class derivative_board;
        rates_t    pending[$];
        int        errors;
        bit [15:0] wheelbase;

        function new();
            errors    = 0;
            wheelbase = 16'd256;
        endfunction

        // arctangent of 2^-i in Q29 by the alternating series
        function longint atan_entry(int i);
            longint unsigned acc;
            longint unsigned span;
            longint unsigned t;
            int k;
            acc = 0;
            if (i == 0) return 64'd421657428;
            for (k = 0; ; k++) begin
                span = longint'(i) * (2 * k + 1);
                if (span > 62) break;
                t = (64'd1 << (62 - span)) / (2 * k + 1);
                if (k % 2 == 1) acc = acc - t;
                else acc = acc + t;
            end
            return longint'((acc + (64'd1 << 32)) >> 33);
        endfunction

        // rotation cordic, Q13 angle in, Q30 cosine and sine out
        function void sin_cos(longint ang, output longint c, output longint s);
            longint z;
            longint x;
            longint y;
            longint dx;
            longint dy;
            longint pi_q29;
            bit     flip;
            z = ang * 65536;
            x = 64'h26DD3B6A;
            y = 0;
            pi_q29 = 64'd1686629713;
            flip = 0;
            if (2 * z > pi_q29) begin
                z = z - pi_q29;
                flip = 1;
            end else if (2 * z < -pi_q29) begin
                z = z + pi_q29;
                flip = 1;
            end
            for (int i = 0; i < CORDIC_STAGES; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - atan_entry(i);
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + atan_entry(i);
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function longint clip(longint v, inout bit flag);
            longint hi;
            longint lo;
            hi = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) begin
                flag = 1;
                return hi;
            end
            if (v < lo) begin
                flag = 1;
                return lo;
            end
            return v;
        endfunction

        // round a Q30 value to an integer, ties away from zero
        function longint round_q30(longint v);
            longint half;
            half = 64'sd1 <<< 29;
            if (v >= 0) return (v + half) >>> 30;
            return -((-v + half) >>> 30);
        endfunction

        // note an accepted input transfer
        function void note(logic signed [15:0] hd, logic signed [14:0] st,
                           logic signed [15:0] sp);
            longint ch, sh, cs, ss, num, den, rh, spd;
            longint unsigned an, ad, q;
            bit     flag;
            rates_t r;
            flag = 0;
            spd = sp;
            sin_cos(longint'(hd), ch, sh);
            sin_cos(longint'(st), cs, ss);
            r.rx = DATA_WIDTH'(clip(round_q30(spd * ch), flag));
            r.ry = DATA_WIDTH'(clip(round_q30(spd * sh), flag));
            num = 256 * spd * ss;
            den = cs * longint'(wheelbase);
            an = (num < 0) ? -num : num;
            ad = (den < 0) ? -den : den;
            if (an == 0) begin
                rh = 0;
            end else if (ad == 0) begin
                rh = (num < 0) ? -64'sd2147483648 : 64'sd2147483647;
                rh = clip(rh * 4, flag);
            end else begin
                q = (an + ad / 2) / ad;
                if (q > (64'd1 << 40)) q = 64'd1 << 40;
                rh = ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
            end
            r.rh  = DATA_WIDTH'(clip(rh, flag));
            r.sat = flag;
            pending.push_back(r);
        endfunction

        // check one result transfer against the oldest expectation
        function void check(logic signed [DATA_WIDTH-1:0] rx, logic signed [DATA_WIDTH-1:0] ry,
                            logic signed [DATA_WIDTH-1:0] rh, logic sat);
            rates_t e;
            if (pending.size() == 0) begin
                $display("%0t: result with nothing expected: %0d %0d %0d %0b",
                         $time, rx, ry, rh, sat);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (rx !== e.rx) begin
                $display("%0t: rate_x expected %0d actual %0d", $time, e.rx, rx);
                errors++;
            end
            if (ry !== e.ry) begin
                $display("%0t: rate_y expected %0d actual %0d", $time, e.ry, ry);
                errors++;
            end
            if (rh !== e.rh) begin
                $display("%0t: rate_heading expected %0d actual %0d", $time, e.rh, rh);
                errors++;
            end
            if (sat !== e.sat) begin
                $display("%0t: saturated expected %0b actual %0b", $time, e.sat, sat);
                errors++;
            end
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic signed [HEADING_W-1:0]  heading;
    logic signed [STEER_W-1:0]    steering;
    logic signed [SPEED_W-1:0]    speed;
    logic                         cfg_we;
    logic [WB_W-1:0]              cfg_wdata;
    logic                         done;
    logic signed [DATA_WIDTH-1:0] rate_x;
    logic signed [DATA_WIDTH-1:0] rate_y;
    logic signed [DATA_WIDTH-1:0] rate_heading;
    logic                         saturated;

    derivative_board board = new();
    int idle_pct;
    int cycles;

    car_kinematic_derivative_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .heading      (heading),
        .steering     (steering),
        .speed        (speed),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .done         (done),
        .rate_x       (rate_x),
        .rate_y       (rate_y),
        .rate_heading (rate_heading),
        .saturated    (saturated)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // input and result transfers seen at the rising edge
    always @(posedge clk) begin
        if (rst_n && start && !busy) board.note(heading, steering, speed);
        if (rst_n && done) board.check(rate_x, rate_y, rate_heading, saturated);
    end

    // run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // one input transfer, with a random gap before it in idle_pct percent of the calls
    task automatic send(logic signed [15:0] hd, logic signed [14:0] st, logic signed [15:0] sp);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(12, 1)) @(negedge clk);
        end
        start    <= 1'b1;
        heading  <= hd;
        steering <= st;
        speed    <= sp;
        @(negedge clk);
        while (busy) @(negedge clk);
    endtask

    // register write once the block has drained
    task automatic set_wheelbase(logic [15:0] wb);
        start <= 1'b0;
        @(negedge clk);
        while (board.pending.size() != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= wb;
        board.wheelbase = wb;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_items(int n);
        logic signed [15:0] sp;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
                0: sp = 16'($urandom_range(65535));
                1: sp = 16'($urandom_range(2047) - 1024);
                2: sp = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                default: sp = 16'($urandom_range(16383) - 8192);
            endcase
            send(16'($urandom_range(65535)), 15'($urandom_range(32767)), sp);
        end
    endtask

    initial begin
        cycles    = 0;
        idle_pct  = 0;
        rst_n     = 1'b0;
        start     = 1'b0;
        heading   = '0;
        steering  = '0;
        speed     = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: field extremes, zero speed, zero steering, angles past half pi
        send(16'sd0, 15'sd0, 16'sd256);
        send(16'sd25736, 15'sd12868, 16'sh7fff);
        send(-16'sd25736, -15'sd12868, 16'sh8000);
        send(16'sh7fff, 15'sh3fff, 16'sh7fff);
        send(16'sh8000, 15'sh4000, 16'sh8000);
        send(16'sd12868, 15'sd0, 16'sd1000);
        send(-16'sd12868, 15'sd6434, -16'sd1000);
        send(16'sd12869, 15'sd12869, 16'sd512);
        send(-16'sd12869, -15'sd12869, 16'sd512);
        send(16'sd6434, 15'sd16000, 16'sd0);
        send(16'sd100, 15'sd12860, 16'sd20000);
        send(-16'sd1, -15'sd1, -16'sd1);
        send(16'sd1, 15'sd1, 16'sd1);
        send(16'sd20000, 15'sd15000, 16'sh7fff);
        send(16'sd0, -15'sd12000, 16'sh8000);

        // phases over several wheelbase settings and idling levels
        set_wheelbase(16'd1);
        random_items(60);
        idle_pct = 86;
        set_wheelbase(16'd65535);
        random_items(60);
        idle_pct = 34;
        set_wheelbase(16'd0);
        random_items(40);
        idle_pct = 0;
        set_wheelbase(16'd256);
        random_items(60);
        idle_pct = 86;
        set_wheelbase(16'($urandom_range(65535, 1)));
        random_items(60);
        idle_pct = 34;
        set_wheelbase(16'($urandom_range(1023, 1)));
        random_items(80);
        idle_pct = 0;
        set_wheelbase(16'($urandom_range(65535, 1)));
        random_items(75);

        // drain
        start <= 1'b0;
        @(negedge clk);
        while (board.pending.size() != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
        if (board.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
